/* rtl/ltsc_pkg.sv */
// Shared types, constants and codes for the tile slot LRU cache.
`timescale 1ns / 1ps
package ltsc_pkg;

  // Cache geometry and field widths.
  localparam int CAPACITY = 128;
  localparam int KEY_BITS = 48;
  localparam int SLOT_W   = 7;
  localparam int CNT_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 8;

  // Reset value of the entry limit register.
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 8'd100;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_PEEK   = 2'd1,
    CMD_REMOVE = 2'd2
  } ltsc_cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_LAYER = 2'd1,
    STAT_ABSENT   = 2'd2
  } ltsc_status_e;

  // One entry of the recency row.
  typedef struct packed {
    logic                valid;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_BITS-1:0] key;
  } ltsc_entry_t;

  // Broadcast to every cell when an item is accepted.
  typedef struct packed {
    logic                accept;
    logic                remove;
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   slot;
  } ltsc_probe_t;

  // Broadcast to every cell in the update cycle.
  typedef struct packed {
    logic              commit;
    logic              shift_all;
    logic              shift_from_hit;
    logic              ins;
    logic [SLOT_W-1:0] ins_pos;
    ltsc_entry_t       new_entry;
  } ltsc_upd_t;

endpackage

/* rtl/ltsc_if.sv */
// Valid/ready channel interfaces for the cache request and result items.
`timescale 1ns / 1ps

interface ltsc_in_if;
  import ltsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [KEY_BITS-1:0]       key;
  logic                      layer_ok;
  logic [SLOT_W-1:0]         slot_in;

  modport source (output valid, cmd, key, layer_ok, slot_in, input ready);
  modport sink   (input valid, cmd, key, layer_ok, slot_in, output ready);
endinterface

interface ltsc_out_if;
  import ltsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [SLOT_W-1:0]         slot_out;
  logic                      reused;
  logic [STAT_W-1:0]         status;

  modport source (output valid, hit, slot_out, reused, status, input ready);
  modport sink   (input valid, hit, slot_out, reused, status, output ready);
endinterface

/* rtl/ltsc_cell.sv */
// One position of the recency row: holds an entry, compares it, shifts from its neighbor.
`timescale 1ns / 1ps
module ltsc_cell import ltsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] idx_i,
  input  ltsc_probe_t       probe_i,
  input  ltsc_upd_t         upd_i,
  input  logic              prefix_i,
  input  ltsc_entry_t       next_i,
  output ltsc_entry_t       entry_o,
  output logic              match_o
);

  logic                valid_q, valid_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                match_q, match_d;
  logic                shift;
  logic                ins_here;

  // Compare against the accepted item: by slot for a remove, by key otherwise.
  always_comb begin
    match_d = match_q;
    if (probe_i.accept) begin
      if (probe_i.remove) begin
        match_d = valid_q && (slot_q == probe_i.slot);
      end else begin
        match_d = valid_q && (key_q == probe_i.key);
      end
    end
  end

  // Insertion wins over taking the neighbor's entry.
  assign shift    = upd_i.commit && (upd_i.shift_all || (upd_i.shift_from_hit && prefix_i));
  assign ins_here = upd_i.commit && upd_i.ins && (upd_i.ins_pos == idx_i);

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    key_d   = key_q;
    if (ins_here) begin
      valid_d = upd_i.new_entry.valid;
      slot_d  = upd_i.new_entry.slot;
      key_d   = upd_i.new_entry.key;
    end else if (shift) begin
      valid_d = next_i.valid;
      slot_d  = next_i.slot;
      key_d   = next_i.key;
    end
  end

  // Control state under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    key_q  <= key_d;
  end

  assign entry_o = '{valid: valid_q, slot: slot_q, key: key_q};
  assign match_o = match_q;

endmodule

/* rtl/lru_tile_slot_cache_core.sv */
// Top level of the tile slot LRU cache: control, slot bookkeeping and the cell row.
// Each item takes a compare step across the cell row, then an update step that shifts the
// recency order and registers the result; the update step waits while an earlier result
// is still held, and no new item is accepted until that update step is done.
// Reset: all cells empty, no slot in use, entry count zero, limit register 100.
`timescale 1ns / 1ps
module lru_tile_slot_cache_core import ltsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  ltsc_in_if.sink           in_i,
  ltsc_out_if.source        out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;
  localparam int   LVLS    = $clog2(CAPACITY);

  logic                state_q, state_d;
  logic [CFG_W-1:0]    max_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAPACITY-1:0] used_q, used_d;

  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic                layer_q;
  logic [SLOT_W-1:0]   slot_in_q;

  logic                out_valid_q, out_valid_d;
  logic                out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic                out_reused_q, out_reused_d;
  logic [STAT_W-1:0]   out_status_q, out_status_d;

  logic                accept;
  logic                upd_go;
  ltsc_probe_t         probe;
  ltsc_upd_t           upd;
  ltsc_entry_t         entries [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pre [LVLS+1];
  logic                any_hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic [SLOT_W-1:0]   free_slot;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    count_m1;

  // Handshake: one item in flight between acceptance and its update cycle.
  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign upd_go      = (state_q == ST_UPD) && (!out_valid_q || out_o.ready);

  assign probe.accept = accept;
  assign probe.remove = (in_i.cmd == CMD_REMOVE);
  assign probe.key    = in_i.key;
  assign probe.slot   = in_i.slot_in;

  // The cell row, oldest entry at position zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ltsc_entry_t nxt;
    if (i == CAPACITY - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = entries[i+1];
    end
    ltsc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (SLOT_W'(i)),
      .probe_i  (probe),
      .upd_i    (upd),
      .prefix_i (pre[LVLS][i]),
      .next_i   (nxt),
      .entry_o  (entries[i]),
      .match_o  (match[i])
    );
  end

  // Prefix OR of the match vector: cells at and after the hit shift down.
  always_comb begin
    pre[0] = match;
    for (int l = 0; l < LVLS; l++) begin
      pre[l+1] = pre[l] | (pre[l] << (1 << l));
    end
  end

  // Slot of the matching cell; at most one cell matches.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_slot = hit_slot | (entries[i].slot & {SLOT_W{match[i]}});
    end
  end
  assign any_hit = |match;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Effective entry limit, clamped to one through capacity.
  always_comb begin
    if (max_q == '0) begin
      limit = CNT_W'(1);
    end else if (max_q > CFG_W'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(max_q);
    end
  end
  assign count_m1 = count_q - CNT_W'(1);

  // Update decision for the item held in the input registers.
  always_comb begin
    upd                = '0;
    upd.commit         = upd_go;
    upd.new_entry.key  = key_q;
    count_d            = count_q;
    used_d             = used_q;
    out_hit_d          = 1'b0;
    out_slot_d         = '0;
    out_reused_d       = 1'b0;
    out_status_d       = STAT_ABSENT;
    case (ltsc_cmd_e'(cmd_q))
      CMD_LOOKUP: begin
        if (any_hit) begin
          upd.shift_from_hit      = 1'b1;
          upd.ins                 = 1'b1;
          upd.ins_pos             = count_m1[SLOT_W-1:0];
          upd.new_entry.valid     = 1'b1;
          upd.new_entry.slot      = hit_slot;
          out_hit_d               = 1'b1;
          out_slot_d              = hit_slot;
          out_status_d            = STAT_OK;
        end else if (!layer_q) begin
          out_status_d            = STAT_NO_LAYER;
        end else if (count_q < limit) begin
          upd.ins                 = 1'b1;
          upd.ins_pos             = count_q[SLOT_W-1:0];
          upd.new_entry.valid     = 1'b1;
          upd.new_entry.slot      = free_slot;
          used_d[free_slot]       = 1'b1;
          count_d                 = count_q + CNT_W'(1);
          out_slot_d              = free_slot;
          out_status_d            = STAT_OK;
        end else begin
          // Evict the oldest entry and reuse its slot at the recent end.
          upd.shift_all           = 1'b1;
          upd.ins                 = 1'b1;
          upd.ins_pos             = count_m1[SLOT_W-1:0];
          upd.new_entry.valid     = 1'b1;
          upd.new_entry.slot      = entries[0].slot;
          out_slot_d              = entries[0].slot;
          out_reused_d            = 1'b1;
          out_status_d            = STAT_OK;
        end
      end
      CMD_PEEK: begin
        if (any_hit) begin
          out_hit_d    = 1'b1;
          out_slot_d   = hit_slot;
          out_status_d = STAT_OK;
        end
      end
      CMD_REMOVE: begin
        if (any_hit) begin
          upd.shift_from_hit = 1'b1;
          used_d[slot_in_q]  = 1'b0;
          count_d            = count_m1;
          out_hit_d          = 1'b1;
          out_slot_d         = slot_in_q;
          out_status_d       = STAT_OK;
        end
      end
      default: begin
        out_status_d = STAT_ABSENT;
      end
    endcase
  end

  // Sequencer and output valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_q       <= MAX_ENTRIES_RST;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (upd_go) begin
        count_q <= count_d;
        used_q  <= used_d;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_i.cmd;
      key_q     <= in_i.key;
      layer_q   <= in_i.layer_ok;
      slot_in_q <= in_i.slot_in;
    end
    if (upd_go) begin
      out_hit_q    <= out_hit_d;
      out_slot_q   <= out_slot_d;
      out_reused_q <= out_reused_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hit      = out_hit_q;
  assign out_o.slot_out = out_slot_q;
  assign out_o.reused   = out_reused_q;
  assign out_o.status   = out_status_q;

endmodule
